// ===== sv/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// shared constants, codes and types of the first-fit pool allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int POOL_BYTES = 4096;
    localparam int GRAN_BYTES = 8;
    localparam int GRAN_SHIFT = 3;
    localparam int NGRAN      = POOL_BYTES / GRAN_BYTES;
    localparam int GIDX_W     = $clog2(NGRAN);
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int NWORD      = NGRAN / WORD_W;
    localparam int WIDX_W     = $clog2(NWORD);
    localparam int CHUNK      = 8;
    localparam int CIDX_W     = $clog2(CHUNK);
    localparam int REQ_W      = 16;
    localparam int STAT_W     = 3;
    localparam int OFF_W      = 12;
    localparam int CNT_W      = 13;

    localparam logic [CNT_W-1:0] FREE_RESET = CNT_W'(NGRAN * GRAN_BYTES);

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_NOTSTART = 3'd3,
        ST_DOUBLE   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        K_ALLOC,
        K_FREE,
        K_ZERO,
        K_NOSPACE,
        K_BADOFF
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [GIDX_W:0]   n;
        logic [GIDX_W-1:0] g;
    } t_cmd;

    typedef struct packed {
        t_status          status;
        logic [OFF_W-1:0] block_offset;
        logic [CNT_W-1:0] block_bytes;
        logic [CNT_W-1:0] bytes_left;
    } t_rsp;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_FSTART,
        B_FEND,
        B_FILL,
        B_EDGE_LO,
        B_EDGE_HI,
        B_DONE
    } t_bstate;

    // lowest set bit of a map word
    function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (w[k]) begin
                r = BIT_W'(k);
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/ffpa_if.sv =====
// ----------------------------------------------------------------------------
// ffpa request / response interfaces
// valid-ready channels of the pool allocator
// ----------------------------------------------------------------------------
interface ffpa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [ffpa_pkg::REQ_W-1:0]   request_bytes;
    logic [ffpa_pkg::REQ_W-1:0]   free_offset;

    modport source (output valid, mode, request_bytes, free_offset, input ready);
    modport sink   (input valid, mode, request_bytes, free_offset, output ready);
endinterface

interface ffpa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ffpa_pkg::STAT_W-1:0]  status;
    logic [ffpa_pkg::OFF_W-1:0]   block_offset;
    logic [ffpa_pkg::CNT_W-1:0]   block_bytes;
    logic [ffpa_pkg::CNT_W-1:0]   bytes_left;

    modport source (output valid, status, block_offset, block_bytes, bytes_left, input ready);
    modport sink   (input valid, status, block_offset, block_bytes, bytes_left, output ready);
endinterface

// ===== sv/ffpa_front.sv =====
// ----------------------------------------------------------------------------
// ffpa_front
// takes requests and sorts them into commands for the engine
// ----------------------------------------------------------------------------
module ffpa_front (
    ffpa_req_if.sink          i_req,
    input  logic              i_full,
    output logic              o_push,
    output ffpa_pkg::t_cmd    o_cmd
);

    logic [ffpa_pkg::REQ_W:0]                    w_sum;
    logic [ffpa_pkg::REQ_W-ffpa_pkg::GRAN_SHIFT:0] w_ngran;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    // round up to whole granules
    assign w_sum   = {1'b0, i_req.request_bytes} + (ffpa_pkg::REQ_W+1)'(ffpa_pkg::GRAN_BYTES - 1);
    assign w_ngran = w_sum[ffpa_pkg::REQ_W:ffpa_pkg::GRAN_SHIFT];

    always_comb begin
        o_cmd.n = w_ngran[ffpa_pkg::GIDX_W:0];
        o_cmd.g = i_req.free_offset[ffpa_pkg::OFF_W-1:ffpa_pkg::GRAN_SHIFT];
        if (!i_req.mode) begin
            if (i_req.request_bytes == '0) begin
                o_cmd.kind = ffpa_pkg::K_ZERO;
            end else if (w_ngran > (ffpa_pkg::REQ_W-ffpa_pkg::GRAN_SHIFT+1)'(ffpa_pkg::NGRAN)) begin
                o_cmd.kind = ffpa_pkg::K_NOSPACE;
            end else begin
                o_cmd.kind = ffpa_pkg::K_ALLOC;
            end
        end else begin
            // beyond the pool or off a granule boundary
            if (i_req.free_offset[ffpa_pkg::REQ_W-1:ffpa_pkg::OFF_W] != '0 ||
                i_req.free_offset[ffpa_pkg::GRAN_SHIFT-1:0] != '0) begin
                o_cmd.kind = ffpa_pkg::K_BADOFF;
            end else begin
                o_cmd.kind = ffpa_pkg::K_FREE;
            end
        end
    end

endmodule

// ===== sv/ffpa_queue.sv =====
// ----------------------------------------------------------------------------
// ffpa_queue
// two-entry command queue between front and engine
// ----------------------------------------------------------------------------
module ffpa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ffpa_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output ffpa_pkg::t_cmd  o_cmd
);

    ffpa_pkg::t_cmd r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;

    assign o_full  = r_cnt[1];
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_slot[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== sv/ffpa_back.sv =====
// ----------------------------------------------------------------------------
// ffpa_back
// allocation engine: first-fit scan, range fill and block edge upkeep
// ----------------------------------------------------------------------------
module ffpa_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  ffpa_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output ffpa_pkg::t_rsp  o_rsp
);

    localparam int GW = ffpa_pkg::GIDX_W;
    localparam int WW = ffpa_pkg::WORD_W;
    localparam int BW = ffpa_pkg::BIT_W;
    localparam int XW = ffpa_pkg::WIDX_W;
    localparam int CW = ffpa_pkg::CNT_W;
    localparam int SH = ffpa_pkg::GRAN_SHIFT;

    ffpa_pkg::t_bstate r_state, n_state;
    ffpa_pkg::t_kind   r_kind, n_kind;
    ffpa_pkg::t_status r_status, n_status;
    logic [GW:0]       r_n, n_n;
    logic [GW:0]       r_pos, n_pos;
    logic [GW-1:0]     r_run_start, n_run_start;
    logic [GW:0]       r_run_len, n_run_len;
    logic [GW-1:0]     r_lo, n_lo;
    logic [GW:0]       r_hi, n_hi;
    logic [GW-1:0]     r_hi_last, n_hi_last;
    logic [XW-1:0]     r_wcur, n_wcur;
    logic [CW-1:0]     r_free, n_free;
    logic              r_out_valid, n_out_valid;
    ffpa_pkg::t_rsp    r_out, n_out;

    logic [WW-1:0]     r_amap [ffpa_pkg::NWORD];
    logic [WW-1:0]     r_smap [ffpa_pkg::NWORD];

    logic              w_awe, w_swe;
    logic [XW-1:0]     w_aidx, w_sidx;
    logic [WW-1:0]     w_adata, w_sdata;

    // scan of one chunk
    logic [GW-1:0]     v_start, v_fs, v_idx;
    logic [GW:0]       v_len;
    logic              v_found;
    logic [ffpa_pkg::CHUNK-1:0] v_chunk;
    logic              w_last_chunk;

    // end-of-block search
    logic [XW-1:0]     w_ew;
    logic [WW-1:0]     w_emask;
    logic              w_ehit;

    // fill mask and edge probes
    logic [WW-1:0]     w_fmask;
    logic [GW-1:0]     w_lo_m1;
    logic [GW:0]       w_span;
    logic              w_need_room;
    logic              w_out_free;

    assign w_span       = r_hi - {1'b0, r_lo};
    assign w_need_room  = {i_cmd.n, {SH{1'b0}}} > r_free;
    assign w_last_chunk = &r_pos[GW-1:ffpa_pkg::CIDX_W];
    assign w_lo_m1      = r_lo - GW'(1);
    assign w_out_free   = !r_out_valid || i_rsp_ready;

    always_comb begin
        v_start = r_run_start;
        v_len   = r_run_len;
        v_found = 1'b0;
        v_fs    = '0;
        v_idx   = '0;
        v_chunk = r_amap[r_pos[GW-1:BW]][{r_pos[BW-1:ffpa_pkg::CIDX_W], {ffpa_pkg::CIDX_W{1'b0}}}
                  +: ffpa_pkg::CHUNK];
        for (int j = 0; j < ffpa_pkg::CHUNK; j++) begin
            v_idx = {r_pos[GW-1:ffpa_pkg::CIDX_W], ffpa_pkg::CIDX_W'(j)};
            if (!v_found) begin
                if (v_chunk[j]) begin
                    v_len = '0;
                end else begin
                    if (v_len == '0) begin
                        v_start = v_idx;
                    end
                    v_len = v_len + (GW+1)'(1);
                    if (v_len == r_n) begin
                        v_found = 1'b1;
                        v_fs    = v_start;
                    end
                end
            end
        end
    end

    assign w_ew    = r_pos[GW-1:BW];
    assign w_emask = r_smap[w_ew] & ({WW{1'b1}} << r_pos[BW-1:0]);
    assign w_ehit  = |w_emask;

    always_comb begin
        for (int j = 0; j < WW; j++) begin
            w_fmask[j] = ({r_wcur, BW'(j)} >= r_lo) && ({r_wcur, BW'(j)} <= r_hi_last);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffpa_pkg::B_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == ffpa_pkg::K_ALLOC) begin
                        n_state = w_need_room ? ffpa_pkg::B_DONE : ffpa_pkg::B_SCAN;
                    end else if (i_cmd.kind == ffpa_pkg::K_FREE) begin
                        n_state = ffpa_pkg::B_FSTART;
                    end else begin
                        n_state = ffpa_pkg::B_DONE;
                    end
                end
            end
            ffpa_pkg::B_SCAN: begin
                if (v_found) begin
                    n_state = ffpa_pkg::B_FILL;
                end else if (w_last_chunk) begin
                    n_state = ffpa_pkg::B_DONE;
                end
            end
            ffpa_pkg::B_FSTART: begin
                if (!r_smap[r_lo[GW-1:BW]][r_lo[BW-1:0]] ||
                    !r_amap[r_lo[GW-1:BW]][r_lo[BW-1:0]]) begin
                    n_state = ffpa_pkg::B_DONE;
                end else begin
                    n_state = ffpa_pkg::B_FEND;
                end
            end
            ffpa_pkg::B_FEND: begin
                if (r_pos[GW] || w_ehit || (&w_ew)) begin
                    n_state = ffpa_pkg::B_FILL;
                end
            end
            ffpa_pkg::B_FILL: begin
                if (r_wcur == r_hi_last[GW-1:BW]) begin
                    n_state = ffpa_pkg::B_EDGE_LO;
                end
            end
            ffpa_pkg::B_EDGE_LO: n_state = ffpa_pkg::B_EDGE_HI;
            ffpa_pkg::B_EDGE_HI: n_state = ffpa_pkg::B_DONE;
            ffpa_pkg::B_DONE: begin
                if (w_out_free) begin
                    n_state = ffpa_pkg::B_IDLE;
                end
            end
            default: n_state = ffpa_pkg::B_IDLE;
        endcase
    end

    // datapath and map writes
    always_comb begin
        n_kind      = r_kind;
        n_status    = r_status;
        n_n         = r_n;
        n_pos       = r_pos;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_hi_last   = r_hi_last;
        n_wcur      = r_wcur;
        n_free      = r_free;
        n_out_valid = r_out_valid && !i_rsp_ready;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        w_awe       = 1'b0;
        w_aidx      = r_wcur;
        w_adata     = r_amap[r_wcur];
        w_swe       = 1'b0;
        w_sidx      = r_lo[GW-1:BW];
        w_sdata     = r_smap[r_lo[GW-1:BW]];
        unique case (r_state)
            ffpa_pkg::B_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop   = 1'b1;
                    n_kind      = i_cmd.kind;
                    n_n         = i_cmd.n;
                    n_lo        = i_cmd.g;
                    n_pos       = '0;
                    n_run_len   = '0;
                    n_run_start = '0;
                    case (i_cmd.kind)
                        ffpa_pkg::K_ZERO:    n_status = ffpa_pkg::ST_ZERO;
                        ffpa_pkg::K_NOSPACE: n_status = ffpa_pkg::ST_NOSPACE;
                        ffpa_pkg::K_BADOFF:  n_status = ffpa_pkg::ST_NOTSTART;
                        ffpa_pkg::K_ALLOC:
                            n_status = w_need_room ? ffpa_pkg::ST_NOSPACE : ffpa_pkg::ST_OK;
                        default:             n_status = ffpa_pkg::ST_OK;
                    endcase
                end
            end
            ffpa_pkg::B_SCAN: begin
                n_pos       = r_pos + (GW+1)'(ffpa_pkg::CHUNK);
                n_run_start = v_start;
                n_run_len   = v_len;
                if (v_found) begin
                    n_lo      = v_fs;
                    n_hi      = {1'b0, v_fs} + r_n;
                    n_hi_last = v_fs + r_n[GW-1:0] - GW'(1);
                    n_wcur    = v_fs[GW-1:BW];
                end else if (w_last_chunk) begin
                    n_status = ffpa_pkg::ST_NOSPACE;
                end
            end
            ffpa_pkg::B_FSTART: begin
                n_pos = {1'b0, r_lo} + (GW+1)'(1);
                if (!r_smap[r_lo[GW-1:BW]][r_lo[BW-1:0]]) begin
                    n_status = ffpa_pkg::ST_NOTSTART;
                end else if (!r_amap[r_lo[GW-1:BW]][r_lo[BW-1:0]]) begin
                    n_status = ffpa_pkg::ST_DOUBLE;
                end
            end
            ffpa_pkg::B_FEND: begin
                n_wcur = r_lo[GW-1:BW];
                if (r_pos[GW] || (!w_ehit && (&w_ew))) begin
                    n_hi      = (GW+1)'(ffpa_pkg::NGRAN);
                    n_hi_last = {GW{1'b1}};
                end else if (w_ehit) begin
                    n_hi      = {1'b0, w_ew, ffpa_pkg::first_set(w_emask)};
                    n_hi_last = {w_ew, ffpa_pkg::first_set(w_emask)} - GW'(1);
                end else begin
                    n_pos = {1'b0, w_ew + XW'(1), {BW{1'b0}}};
                end
            end
            ffpa_pkg::B_FILL: begin
                w_awe   = 1'b1;
                w_adata = (r_kind == ffpa_pkg::K_ALLOC) ? (r_amap[r_wcur] | w_fmask)
                                                        : (r_amap[r_wcur] & ~w_fmask);
                n_wcur  = r_wcur + XW'(1);
            end
            ffpa_pkg::B_EDGE_LO: begin
                if (r_kind == ffpa_pkg::K_ALLOC) begin
                    w_swe = 1'b1;
                    w_sdata[r_lo[BW-1:0]] = 1'b1;
                end else if (r_lo != '0 && !r_amap[w_lo_m1[GW-1:BW]][w_lo_m1[BW-1:0]]) begin
                    // merge with a free run below
                    w_swe = 1'b1;
                    w_sdata[r_lo[BW-1:0]] = 1'b0;
                end
            end
            ffpa_pkg::B_EDGE_HI: begin
                w_sidx  = r_hi[GW-1:BW];
                w_sdata = r_smap[r_hi[GW-1:BW]];
                if (!r_hi[GW] && !r_amap[r_hi[GW-1:BW]][r_hi[BW-1:0]]) begin
                    // split remainder on allocate, merge with free run above on free
                    w_swe = 1'b1;
                    w_sdata[r_hi[BW-1:0]] = (r_kind == ffpa_pkg::K_ALLOC);
                end
                if (r_kind == ffpa_pkg::K_ALLOC) begin
                    n_free = r_free - {w_span[CW-SH-1:0], {SH{1'b0}}};
                end else begin
                    n_free = r_free + {w_span[CW-SH-1:0], {SH{1'b0}}};
                end
            end
            ffpa_pkg::B_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.status = r_status;
                    n_out.bytes_left = r_free;
                    if (r_status == ffpa_pkg::ST_OK) begin
                        n_out.block_offset = {r_lo, {SH{1'b0}}};
                        n_out.block_bytes  = {w_span[CW-SH-1:0], {SH{1'b0}}};
                    end else begin
                        n_out.block_offset = '0;
                        n_out.block_bytes  = '0;
                    end
                end
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffpa_pkg::B_IDLE;
            r_out_valid <= 1'b0;
            r_free      <= ffpa_pkg::FREE_RESET;
            for (int k = 0; k < ffpa_pkg::NWORD; k++) begin
                r_amap[k] <= '0;
                r_smap[k] <= (k == 0) ? WW'(1) : '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_free      <= n_free;
            if (w_awe) begin
                r_amap[w_aidx] <= w_adata;
            end
            if (w_swe) begin
                r_smap[w_sidx] <= w_sdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_status    <= n_status;
        r_n         <= n_n;
        r_pos       <= n_pos;
        r_run_start <= n_run_start;
        r_run_len   <= n_run_len;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_hi_last   <= n_hi_last;
        r_wcur      <= n_wcur;
        r_out       <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

// ===== sv/first_fit_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_unit
// first-fit allocator over a 4096-byte pool of 8-byte granules, with coalescing
// ----------------------------------------------------------------------------
//  channel   dir   carries
//  i_req     in    mode, request_bytes, free_offset
//  o_rsp     out   status, block_offset, block_bytes, bytes_left
//
//  allocate: first-fit scan (8 granules a cycle), fill of each map word covered
//  (1..16), edge upkeep; free: start check, end search, fill and edge upkeep
//  one item is in the engine at a time; two more wait in the command queue
//  reset is synchronous and leaves the whole pool as one free block at once
//  a stalled response holds the engine in its last state, not the queue
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffpa_req_if.sink   i_req,
    ffpa_rsp_if.source o_rsp
);

    logic           w_push, w_full, w_qvalid, w_pop;
    ffpa_pkg::t_cmd w_fcmd, w_qcmd;
    ffpa_pkg::t_rsp w_rsp;

    ffpa_front u_front (
        .i_req  (i_req),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_fcmd)
    );

    ffpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_fcmd),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .i_pop   (w_pop),
        .o_cmd   (w_qcmd)
    );

    ffpa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_qvalid),
        .i_cmd       (w_qcmd),
        .o_cmd_pop   (w_pop),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (w_rsp)
    );

    assign o_rsp.status       = w_rsp.status;
    assign o_rsp.block_offset = w_rsp.block_offset;
    assign o_rsp.block_bytes  = w_rsp.block_bytes;
    assign o_rsp.bytes_left   = w_rsp.bytes_left;

endmodule

// ===== sv/ffpa_checker.sv =====
// ----------------------------------------------------------------------------
// ffpa_checker
// port-level checks of the pool allocator
// ----------------------------------------------------------------------------
module ffpa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic [ffpa_pkg::STAT_W-1:0]  i_status,
    input logic [ffpa_pkg::OFF_W-1:0]   i_block_offset,
    input logic [ffpa_pkg::CNT_W-1:0]   i_block_bytes,
    input logic [ffpa_pkg::CNT_W-1:0]   i_bytes_left
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("response dropped while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != ffpa_pkg::ST_OK |-> i_block_offset == '0 && i_block_bytes == '0)
        else $error("failed request reports a block");

    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ffpa_pkg::ST_OK |->
            i_block_bytes != '0 && i_block_bytes[ffpa_pkg::GRAN_SHIFT-1:0] == '0)
        else $error("granted block not a whole number of granules");

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_bytes_left <= ffpa_pkg::FREE_RESET)
        else $error("free byte count above pool size");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("response valid right after reset");

endmodule

bind first_fit_pool_allocator_unit ffpa_checker u_ffpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_rsp.valid),
    .i_ready        (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_block_offset (o_rsp.block_offset),
    .i_block_bytes  (o_rsp.block_bytes),
    .i_bytes_left   (o_rsp.bytes_left)
);

// ===== tb/tb_first_fit_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_pool_allocator_unit
// random and directed alloc/free traffic against a granule-map predictor
// ----------------------------------------------------------------------------
module tb_first_fit_pool_allocator_unit;

    typedef struct packed {
        logic                       mode;
        logic [ffpa_pkg::REQ_W-1:0] request_bytes;
        logic [ffpa_pkg::REQ_W-1:0] free_offset;
    } t_word;

    logic i_clk;
    logic i_rst_n;

    ffpa_req_if req_if ();
    ffpa_rsp_if rsp_if ();

    first_fit_pool_allocator_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    logic [ffpa_pkg::NGRAN-1:0] pool_used;
    logic [ffpa_pkg::NGRAN-1:0] pred_starts;
    int unsigned                pred_left;

    t_word          pending_words[$];
    ffpa_pkg::t_rsp expected_rsps[$];
    int    n_errors;
    int    n_accepted;
    int    n_checked;
    bit    stim_done;
    bit    quiet;
    bit    hold_sender;
    longint cycles;

    function automatic ffpa_pkg::t_rsp predict_request(input t_word w);
        ffpa_pkg::t_rsp r;
        int   n, i, s, e;
        r = '{status: ffpa_pkg::ST_OK, block_offset: '0, block_bytes: '0, bytes_left: '0};
        if (!w.mode) begin
            if (w.request_bytes == 0) begin
                r.status = ffpa_pkg::ST_ZERO;
            end else begin
                n = (int'(w.request_bytes) + ffpa_pkg::GRAN_BYTES - 1) / ffpa_pkg::GRAN_BYTES;
                r.status = ffpa_pkg::ST_NOSPACE;
                if (n * ffpa_pkg::GRAN_BYTES <= pred_left) begin
                    i = 0;
                    while (i < ffpa_pkg::NGRAN && r.status != ffpa_pkg::ST_OK) begin
                        if (pool_used[i]) begin
                            i++;
                        end else begin
                            s = i;
                            while (i < ffpa_pkg::NGRAN && !pool_used[i]) i++;
                            if (i - s >= n) begin
                                for (int k = s; k < s + n; k++) pool_used[k] = 1'b1;
                                pred_starts[s] = 1'b1;
                                if (n < i - s) pred_starts[s + n] = 1'b1;
                                pred_left -= n * ffpa_pkg::GRAN_BYTES;
                                r.status = ffpa_pkg::ST_OK;
                                r.block_offset = ffpa_pkg::OFF_W'(s * ffpa_pkg::GRAN_BYTES);
                                r.block_bytes = ffpa_pkg::CNT_W'(n * ffpa_pkg::GRAN_BYTES);
                            end
                        end
                    end
                end
            end
        end else begin
            s = int'(w.free_offset) / ffpa_pkg::GRAN_BYTES;
            if (w.free_offset >= ffpa_pkg::NGRAN * ffpa_pkg::GRAN_BYTES
                || w.free_offset % ffpa_pkg::GRAN_BYTES != 0
                || !pred_starts[s]) begin
                r.status = ffpa_pkg::ST_NOTSTART;
            end else if (!pool_used[s]) begin
                r.status = ffpa_pkg::ST_DOUBLE;
            end else begin
                e = s + 1;
                while (e < ffpa_pkg::NGRAN && !pred_starts[e]) e++;
                for (int k = s; k < e; k++) pool_used[k] = 1'b0;
                pred_left += (e - s) * ffpa_pkg::GRAN_BYTES;
                if (s > 0 && !pool_used[s - 1]) pred_starts[s] = 1'b0;
                if (e < ffpa_pkg::NGRAN && !pool_used[e]) pred_starts[e] = 1'b0;
                r.block_offset = ffpa_pkg::OFF_W'(w.free_offset);
                r.block_bytes = ffpa_pkg::CNT_W'((e - s) * ffpa_pkg::GRAN_BYTES);
            end
        end
        r.bytes_left = ffpa_pkg::CNT_W'(pred_left);
        return r;
    endfunction

    function automatic t_word alloc_word(input int bytes);
        t_word w;
        w.mode = 1'b0;
        w.request_bytes = ffpa_pkg::REQ_W'(bytes);
        w.free_offset = ffpa_pkg::REQ_W'($urandom);
        return w;
    endfunction

    function automatic t_word free_word(input int offset);
        t_word w;
        w.mode = 1'b1;
        w.request_bytes = ffpa_pkg::REQ_W'($urandom);
        w.free_offset = ffpa_pkg::REQ_W'(offset);
        return w;
    endfunction

    // driver
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                n_accepted <= n_accepted + 1;
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_gap > 0) begin
                    req_if.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_words.size() > 0 && !hold_sender) begin
                    t_word w;
                    w = pending_words.pop_front();
                    expected_rsps.push_back(predict_request(w));
                    req_if.valid <= 1'b1;
                    req_if.mode <= w.mode;
                    req_if.request_bytes <= w.request_bytes;
                    req_if.free_offset <= w.free_offset;
                    if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 17);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int stall_left;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("response with nothing expected");
                    n_errors <= n_errors + 1;
                end else begin
                    ffpa_pkg::t_rsp x;
                    int             errs;
                    errs = 0;
                    x = expected_rsps.pop_front();
                    n_checked <= n_checked + 1;
                    if (rsp_if.status !== x.status) begin
                        $error("status exp %0d got %0d", x.status, rsp_if.status);
                        errs++;
                    end
                    if (rsp_if.block_offset !== x.block_offset) begin
                        $error("block_offset exp %0d got %0d", x.block_offset,
                               rsp_if.block_offset);
                        errs++;
                    end
                    if (rsp_if.block_bytes !== x.block_bytes) begin
                        $error("block_bytes exp %0d got %0d", x.block_bytes,
                               rsp_if.block_bytes);
                        errs++;
                    end
                    if (rsp_if.bytes_left !== x.bytes_left) begin
                        $error("bytes_left exp %0d got %0d", x.bytes_left,
                               rsp_if.bytes_left);
                        errs++;
                    end
                    if (errs != 0) begin
                        n_errors <= n_errors + errs;
                    end
                end
            end
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rsp_if.ready <= 1'b0;
                stall_left <= $urandom_range(0, 16);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    task automatic gen_block(input int count);
        int pick, off;
        for (int j = 0; j < count; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // mostly small sizes, a few big ones
                if ($urandom_range(0, 19) == 0) pending_words.push_back(alloc_word(
                    $urandom_range(1, 4096)));
                else pending_words.push_back(alloc_word($urandom_range(1, 200)));
            end else if (pick < 85) begin
                // free a block start guess: a multiple of the granule, often low
                off = $urandom_range(0, 127) * ffpa_pkg::GRAN_BYTES
                      * ($urandom_range(0, 3) == 0 ? 4 : 1);
                pending_words.push_back(free_word(off % ffpa_pkg::POOL_BYTES));
            end else if (pick < 92) begin
                pending_words.push_back(free_word($urandom_range(0, 65535)));
            end else if (pick < 96) begin
                pending_words.push_back(alloc_word($urandom_range(0, 65535)));
            end else begin
                pending_words.push_back(alloc_word(0));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || expected_rsps.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.mode = 1'b0;
        req_if.request_bytes = '0;
        req_if.free_offset = '0;
        rsp_if.ready = 1'b0;
        n_errors = 0;
        n_accepted = 0;
        n_checked = 0;
        cycles = 0;
        quiet = 1'b0;
        hold_sender = 1'b0;
        stim_done = 1'b0;
        pool_used = '0;
        pred_starts = '0;
        pred_starts[0] = 1'b1;
        pred_left = ffpa_pkg::NGRAN * ffpa_pkg::GRAN_BYTES;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero size, rounding, split, frees, merges, errors
        pending_words.push_back(alloc_word(0));
        pending_words.push_back(alloc_word(1));
        pending_words.push_back(alloc_word(8));
        pending_words.push_back(alloc_word(9));
        pending_words.push_back(alloc_word(65535));
        pending_words.push_back(free_word(8));
        pending_words.push_back(free_word(8));
        pending_words.push_back(free_word(12));
        pending_words.push_back(free_word(16));
        pending_words.push_back(free_word(65535));
        pending_words.push_back(free_word(4096));
        pending_words.push_back(free_word(0));
        pending_words.push_back(free_word(0));
        pending_words.push_back(alloc_word(4096));
        pending_words.push_back(alloc_word(1));
        pending_words.push_back(free_word(0));
        pending_words.push_back(alloc_word(4088));
        pending_words.push_back(alloc_word(8));
        pending_words.push_back(free_word(4088));
        pending_words.push_back(free_word(0));
        pending_words.push_back(free_word(4088));
        wait_drained();

        // run a random block until the block has answered everything, then pause the sender
        gen_block(200);
        wait_drained();
        hold_sender = 1'b1;
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b0;
        gen_block(200);
        wait_drained();
        quiet = 1'b1;
        gen_block(130);
        wait_drained();
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        repeat (200) @(posedge i_clk);
        if (expected_rsps.size() != 0) begin
            $error("%0d responses never arrived", expected_rsps.size());
            n_errors = n_errors + 1;
        end
        $display("run covered %0d requests and %0d checked responses", n_accepted, n_checked);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        wait (cycles > 400000);
        $display("timeout after %0d cycles", cycles);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
